// ===== rtl/clns_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; imported by every module of the block.
package clns_pkg;

    // Request beat as it arrives on the input channel
    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic       line_sel;
        logic [5:0] column;
    } req_t;

    // One bus step on the output channel
    typedef struct packed {
        logic        drive_pulse;
        logic [3:0]  nibble;
        logic        reg_select;
        logic [7:0]  enable_high_us;
        logic [15:0] wait_after_us;
        logic        last;
    } step_t;

    // Live configuration handed to the back end
    typedef struct packed {
        logic [7:0]  enable_pulse_us;
        logic [7:0]  settle_us;
        logic [15:0] long_wait_us;
    } cfg_t;

    // Request kinds
    localparam logic [2:0] REQ_CMD   = 3'd0;
    localparam logic [2:0] REQ_DATA  = 3'd1;
    localparam logic [2:0] REQ_INIT  = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_POS   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_SETTLE       = 2'd1;
    localparam logic [1:0] CFG_LONG_WAIT    = 2'd2;

    // Operations passed from front to back
    typedef enum logic [1:0] {
        OP_WAIT = 2'd0,  // wait-only step
        OP_NIB  = 2'd1,  // single nibble, fixed wait
        OP_BYTE = 2'd2   // two nibbles, settle wait plus extra
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  value;
        logic        rs;
        logic [15:0] wait_us;  // full wait for OP_WAIT/OP_NIB, extra for OP_BYTE
        logic        last;
    } op_t;

    // Operation queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Init run: one pause, four nibbles, six commands
    localparam int          SEQ_W         = 4;
    localparam logic [3:0]  INIT_LAST_SEQ = 4'd10;

    localparam logic [15:0] WAIT_POWER_UP = 16'd30000;
    localparam logic [15:0] WAIT_FIRST    = 16'd6000;
    localparam logic [15:0] WAIT_SHORT    = 16'd100;
    localparam logic [15:0] WAIT_CLEAR    = 16'd3000;

    localparam logic [7:0]  POS_BASE      = 8'h80;
    localparam logic [7:0]  POS_LINE_ODD  = 8'h40;
    localparam logic [7:0]  CMD_CLEAR     = 8'h01;
    localparam logic [7:0]  CMD_HOME      = 8'h02;

    // Operation for one position of the init run
    function automatic op_t init_op(input logic [SEQ_W-1:0] seq);
        op_t op;
        op.kind    = OP_BYTE;
        op.value   = 8'h00;
        op.rs      = 1'b0;
        op.wait_us = WAIT_SHORT;
        op.last    = 1'b0;
        unique case (seq) inside
            4'd0:
            begin
                op.kind    = OP_WAIT;
                op.wait_us = WAIT_POWER_UP;
            end
            4'd1:
            begin
                op.kind    = OP_NIB;
                op.value   = 8'h03;
                op.wait_us = WAIT_FIRST;
            end
            4'd2, 4'd3:
            begin
                op.kind  = OP_NIB;
                op.value = 8'h03;
            end
            4'd4:
            begin
                op.kind  = OP_NIB;
                op.value = 8'h02;
            end
            4'd5:  op.value = 8'h08;
            4'd6:  op.value = 8'h28;
            4'd7:  op.value = 8'h08;
            4'd8:  op.value = 8'h01;
            4'd9:  op.value = 8'h06;
            4'd10:
            begin
                op.value = 8'h0C;
                op.last  = 1'b1;
            end
            default: op.kind = OP_WAIT;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/clns_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and expands each into operations.
// Depends on clns_pkg; feeds clns_queue.
module clns_front import clns_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  req_t in_data,
    output logic push,
    output op_t  push_op,
    input  logic q_full
);

    logic             busy_reg,  busy_next;
    logic [2:0]       kind_reg,  kind_next;
    logic [SEQ_W-1:0] seq_reg,   seq_next;
    logic [7:0]       byte_reg,  byte_next;
    logic             accept;
    logic [7:0]       pos_byte;

    // Position command, computed in eight bits; the largest value is 8'hFF
    assign pos_byte = POS_BASE + {2'b00, in_data.column}
                    + (in_data.line_sel ? POS_LINE_ODD : 8'h00);

    // Operation for the current position of the run
    always_comb
    begin
        push_op.kind    = OP_BYTE;
        push_op.value   = byte_reg;
        push_op.rs      = 1'b0;
        push_op.wait_us = 16'd0;
        push_op.last    = 1'b1;
        unique case (kind_reg) inside
            REQ_CMD, REQ_POS: ;
            REQ_DATA: push_op.rs = 1'b1;
            REQ_INIT: push_op = init_op(seq_reg);
            REQ_CLEAR:
            begin
                push_op.value   = (seq_reg == '0) ? CMD_CLEAR : CMD_HOME;
                push_op.wait_us = WAIT_CLEAR;
                push_op.last    = (seq_reg != '0);
            end
            default: push_op.kind = OP_WAIT;
        endcase
    end

    assign push     = busy_reg && !q_full;
    assign in_stall = busy_reg && !(push && push_op.last);
    assign accept   = in_valid && !in_stall;

    // Run sequencing
    always_comb
    begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        seq_next  = seq_reg;
        byte_next = byte_reg;
        if (push)
        begin
            seq_next = seq_reg + 1'b1;
            if (push_op.last)
                busy_next = 1'b0;
        end
        if (accept)
        begin
            // unknown kinds are taken and dropped
            busy_next = (in_data.req_type <= REQ_POS);
            kind_next = in_data.req_type;
            seq_next  = '0;
            byte_next = (in_data.req_type == REQ_POS) ? pos_byte : in_data.byte_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            kind_reg <= REQ_CMD;
            seq_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            kind_reg <= kind_next;
            seq_reg  <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ===== rtl/clns_queue.sv =====
`timescale 1ns / 1ps
// Short operation queue between front and back end.
// Depends on clns_pkg (op_t, QDEPTH).
module clns_queue import clns_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  pop_op,
    output logic empty
);

    op_t            mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full   = (count_reg == (QAW+1)'(QDEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/clns_back.sv =====
`timescale 1ns / 1ps
// Back end: turns queued operations into bus steps, one step a cycle while the output is not stalled.
// Depends on clns_pkg; reads clns_queue and the configuration registers.
module clns_back import clns_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_empty,
    input  op_t   q_op,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_stall,
    output step_t out_data
);

    logic        out_valid_reg;
    step_t       out_reg, out_next;
    logic        pend_reg, pend_next;
    op_t         hold_reg;
    logic        load;
    logic        add_long;
    logic [17:0] low_sum;
    logic [15:0] low_wait;

    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !pend_reg && !q_empty;

    // Final wait of a byte: settle plus extra, long wait on commands 1 to 3
    assign add_long = !hold_reg.rs && (hold_reg.value >= 8'd1) && (hold_reg.value <= 8'd3);
    assign low_sum  = {10'd0, cfg.settle_us} + {2'd0, hold_reg.wait_us}
                    + (add_long ? {2'd0, cfg.long_wait_us} : 18'd0);
    assign low_wait = (low_sum[17:16] != 2'd0) ? 16'hFFFF : low_sum[15:0];

    // Step selection
    always_comb
    begin
        out_next                = '0;
        pend_next               = pend_reg;
        if (pend_reg)
        begin
            out_next.drive_pulse    = 1'b1;
            out_next.nibble         = hold_reg.value[3:0];
            out_next.reg_select     = hold_reg.rs;
            out_next.enable_high_us = cfg.enable_pulse_us;
            out_next.wait_after_us  = low_wait;
            out_next.last           = hold_reg.last;
            pend_next               = 1'b0;
        end
        else if (!q_empty)
        begin
            unique case (q_op.kind)
                OP_WAIT:
                begin
                    out_next.wait_after_us = q_op.wait_us;
                    out_next.last          = q_op.last;
                end
                OP_NIB:
                begin
                    out_next.drive_pulse    = 1'b1;
                    out_next.nibble         = q_op.value[3:0];
                    out_next.reg_select     = q_op.rs;
                    out_next.enable_high_us = cfg.enable_pulse_us;
                    out_next.wait_after_us  = q_op.wait_us;
                    out_next.last           = q_op.last;
                end
                OP_BYTE:
                begin
                    out_next.drive_pulse    = 1'b1;
                    out_next.nibble         = q_op.value[7:4];
                    out_next.reg_select     = q_op.rs;
                    out_next.enable_high_us = cfg.enable_pulse_us;
                    pend_next               = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= pend_reg || !q_empty;
            if (pend_reg || !q_empty)
                pend_reg <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
        if (pop)
            hold_reg <= q_op;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A pending low nibble means its high nibble is on the output
    a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg && out_reg.drive_pulse)
        else $error("low nibble pending without high nibble on output");

    // The high nibble of a byte never closes a request
    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_reg.last)
        else $error("high nibble marked last");

    // Wait-only steps carry no pins and no enable time
    a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.drive_pulse) |->
            (out_reg.nibble == 4'd0 && !out_reg.reg_select && out_reg.enable_high_us == 8'd0))
        else $error("wait-only step drives the bus");

endmodule

// ===== rtl/char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the character LCD nibble sequencer: configuration registers and wiring.
// Depends on clns_pkg, clns_front, clns_queue and clns_back.
//
// Each request is expanded into a run of LCD bus steps, one step per output beat.
// The back end emits one step per clock while the output is not stalled; a command,
// data or position request gives 2 steps, clear and home 4 and init 17; requests of
// kinds 5 to 7 are taken and produce nothing. The front end queues one operation per
// cycle, while the queue is not full, into a four-entry queue and takes the next request
// in the cycle it queues the last operation of the current one, so a new request can be
// taken while the steps of earlier ones are still queued. Configuration writes are always
// ready and take effect on steps produced after the write; index 3 is ignored.
module char_lcd_nibble_sequencer import clns_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output step_t       out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_empty;
    op_t  q_push_op, q_pop_op;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse_us <= 8'd5;
            cfg_reg.settle_us       <= 8'd45;
            cfg_reg.long_wait_us    <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE_PULSE: cfg_reg.enable_pulse_us <= cfg_data[7:0];
                CFG_SETTLE:       cfg_reg.settle_us       <= cfg_data[7:0];
                CFG_LONG_WAIT:    cfg_reg.long_wait_us    <= cfg_data;
                default: ;
            endcase
        end
    end

    clns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (q_push),
        .push_op  (q_push_op),
        .q_full   (q_full)
    );

    clns_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_pop_op),
        .empty   (q_empty)
    );

    clns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_op      (q_pop_op),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== dv/tb_char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_sequencer: request beats in, LCD bus steps out.
// Depends on clns_pkg and the RTL top level; a step predictor in the scoreboard checks each beat.
module tb_char_lcd_nibble_sequencer;
    import clns_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 160;
    localparam int          STALL_LIMIT   = 3000;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic [2:0]  REQ_BAD_LO    = 3'd5;
    localparam logic [2:0]  REQ_BAD_HI    = 3'd7;

    // Predicts the bus steps of each request and checks them in order
    class step_scoreboard;
        logic [7:0]  enable_us;
        logic [7:0]  settle;
        logic [15:0] long_wait;
        step_t       due[$];
        int          errors;
        int          steps_seen;
        int          requests_seen;
        int          ignored_seen;

        function new();
            enable_us     = 8'd5;
            settle        = 8'd45;
            long_wait     = 16'd2000;
            errors        = 0;
            steps_seen    = 0;
            requests_seen = 0;
            ignored_seen  = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_ENABLE_PULSE: enable_us = val[7:0];
                CFG_SETTLE:       settle    = val[7:0];
                CFG_LONG_WAIT:    long_wait = val;
                default:          ;
            endcase
        endfunction

        // One step; wait-only steps carry zero nibble, RS and enable time
        function void add_step(bit drive, logic [3:0] nib, bit rs, int unsigned wait_us);
            step_t s;
            s.drive_pulse    = drive;
            s.nibble         = drive ? nib : 4'd0;
            s.reg_select     = drive ? rs : 1'b0;
            s.enable_high_us = drive ? enable_us : 8'd0;
            s.wait_after_us  = (wait_us > 32'hFFFF) ? 16'hFFFF : wait_us[15:0];
            s.last           = 1'b0;
            due.push_back(s);
        endfunction

        // High nibble then low nibble; settle plus extra after the second
        function void add_byte(logic [7:0] b, bit rs, int unsigned extra);
            int unsigned w;
            w = settle + extra;
            if (!rs && b >= 8'd1 && b <= 8'd3)
                w += long_wait;
            add_step(1'b1, b[7:4], rs, 0);
            add_step(1'b1, b[3:0], rs, w);
        endfunction

        function void note_request(req_t r);
            logic [7:0] pos;
            requests_seen++;
            case (r.req_type)
                REQ_CMD:  add_byte(r.byte_value, 1'b0, 0);
                REQ_DATA: add_byte(r.byte_value, 1'b1, 0);
                REQ_INIT:
                begin
                    add_step(1'b0, 4'd0, 1'b0, 30000);
                    add_step(1'b1, 4'h3, 1'b0, 6000);
                    add_step(1'b1, 4'h3, 1'b0, 100);
                    add_step(1'b1, 4'h3, 1'b0, 100);
                    add_step(1'b1, 4'h2, 1'b0, 100);
                    add_byte(8'h08, 1'b0, 100);
                    add_byte(8'h28, 1'b0, 100);
                    add_byte(8'h08, 1'b0, 100);
                    add_byte(8'h01, 1'b0, 100);
                    add_byte(8'h06, 1'b0, 100);
                    add_byte(8'h0C, 1'b0, 100);
                end
                REQ_CLEAR:
                begin
                    add_byte(8'h01, 1'b0, 3000);
                    add_byte(8'h02, 1'b0, 3000);
                end
                REQ_POS:
                begin
                    pos = 8'h80 + {2'b00, r.column} + (r.line_sel ? 8'h40 : 8'h00);
                    add_byte(pos, 1'b0, 0);
                end
                default:
                begin
                    // unknown kinds are swallowed without a step
                    ignored_seen++;
                    return;
                end
            endcase
            due[due.size() - 1].last = 1'b1;
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("step %0d %s got %h want %h", steps_seen, field, got, want));
        endtask

        task check_step(step_t got);
            step_t want;
            steps_seen++;
            if (due.size() == 0)
            begin
                report($sformatf("step %0d (%h) arrived with nothing expected",
                                 steps_seen, got));
                return;
            end
            want = due.pop_front();
            compare_field("drive_pulse", 16'(got.drive_pulse), 16'(want.drive_pulse));
            compare_field("nibble", 16'(got.nibble), 16'(want.nibble));
            compare_field("reg_select", 16'(got.reg_select), 16'(want.reg_select));
            compare_field("enable_high_us", 16'(got.enable_high_us), 16'(want.enable_high_us));
            compare_field("wait_after_us", got.wait_after_us, want.wait_after_us);
            compare_field("last", 16'(got.last), 16'(want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        in_data;
    logic        out_valid;
    logic        out_stall;
    step_t       out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    step_scoreboard sb = new();
    int unsigned    idle_pct  = 0;
    int unsigned    stall_pct = 0;
    int             hold_asked  = 0;
    int             hold_served = 0;
    int             settings    = 1;
    int             quiet_cycles = 0;

    char_lcd_nibble_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Beat monitor: requests go to the predictor, steps to the checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_data);
            if (out_valid && !out_stall)
                sb.check_step(out_data);
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic req_t make_req(logic [2:0] kind, logic [7:0] b, logic line,
                                      logic [5:0] col);
        req_t r;
        r.req_type   = kind;
        r.byte_value = b;
        r.line_sel   = line;
        r.column     = col;
        return r;
    endfunction

    // Mostly short bytes, some clear/init, a tenth unknown kinds
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r = make_req(3'($urandom), 8'($urandom), 1'($urandom), 6'($urandom));
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            r.req_type = REQ_CMD;
            if ($urandom_range(3) == 0)
                r.byte_value = 8'($urandom_range(3, 1));
        end
        else if (pick < 58)
            r.req_type = REQ_DATA;
        else if (pick < 78)
            r.req_type = REQ_POS;
        else if (pick < 85)
            r.req_type = REQ_CLEAR;
        else if (pick < 90)
            r.req_type = REQ_INIT;
        else
            r.req_type = 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
        return r;
    endfunction

    // Offer one request, with a random gap first, and wait for its beat
    task automatic send_request(input req_t r);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sent;
        req_t        r;
        sent = 0;
        while (sent < count)
        begin
            r = random_request();
            send_request(r);
            if (r.req_type <= REQ_POS)
                sent++;
        end
    endtask

    // Stop offering and wait for every predicted step, then a margin
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // Upper byte of the 8-bit registers is junk on purpose
    task automatic write_config(input logic [7:0] en, input logic [7:0] st,
                                input logic [15:0] lw);
        write_reg(CFG_ENABLE_PULSE, {8'($urandom), en});
        write_reg(CFG_SETTLE, {8'($urandom), st});
        write_reg(CFG_LONG_WAIT, lw);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENABLE_PULSE;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, long-wait codes, every kind, unknown kinds
        send_request(make_req(REQ_CMD, 8'h00, 1'b0, 6'd0));
        send_request(make_req(REQ_CMD, 8'h01, 1'b1, 6'd63));
        send_request(make_req(REQ_CMD, 8'h02, 1'b0, 6'd0));
        send_request(make_req(REQ_CMD, 8'h03, 1'b1, 6'd63));
        send_request(make_req(REQ_CMD, 8'h04, 1'b0, 6'd0));
        send_request(make_req(REQ_CMD, 8'hFF, 1'b1, 6'd63));
        send_request(make_req(REQ_DATA, 8'h00, 1'b0, 6'd0));
        send_request(make_req(REQ_DATA, 8'hFF, 1'b1, 6'd63));
        send_request(make_req(REQ_DATA, 8'h5A, 1'b0, 6'd21));
        send_request(make_req(REQ_INIT, 8'h00, 1'b0, 6'd0));
        send_request(make_req(REQ_CLEAR, 8'hFF, 1'b1, 6'd63));
        send_request(make_req(REQ_POS, 8'h00, 1'b0, 6'd0));
        send_request(make_req(REQ_POS, 8'hFF, 1'b1, 6'd63));
        send_request(make_req(REQ_POS, 8'h00, 1'b0, 6'd63));
        send_request(make_req(REQ_POS, 8'h00, 1'b1, 6'd0));
        for (int k = REQ_BAD_LO; k <= REQ_BAD_HI; k++)
            send_request(make_req(3'(k), 8'($urandom), 1'($urandom), 6'($urandom)));
        send_request(make_req(REQ_DATA, 8'hA5, 1'b1, 6'd42));
        drain();

        // Free flow, random settings
        write_config(8'($urandom_range(254, 1)), 8'($urandom), 16'($urandom));
        run_random(40);
        drain();

        // Sparse sender, top settings so long waits saturate
        write_config(8'hFF, 8'hFF, 16'hFFFF);
        idle_pct = 58;
        run_random(16);
        drain();
        run_random(20);
        drain();

        // Stalling receiver, zero pulse and zero waits
        write_config(8'h00, 8'h00, 16'h0000);
        idle_pct  = 0;
        stall_pct = 58;
        run_random(40);
        drain();

        // Both sides idle a little; long hold-off fills the block mid-phase
        write_reg(CFG_UNUSED, 16'($urandom));
        write_config(8'($urandom_range(255, 1)), 8'($urandom), 16'($urandom));
        idle_pct  = 16;
        stall_pct = 16;
        run_random(12);
        hold_asked++;
        run_random(24);
        drain();

        $display("Summary: %0d requests (%0d of unknown kind) gave %0d bus steps over %0d settings,",
                 sb.requests_seen, sb.ignored_seen, sb.steps_seen, settings);
        $display("with input gaps, output stalls, one long output hold-off and drains between.");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/clns_pkg.sv
rtl/clns_front.sv
rtl/clns_queue.sv
rtl/clns_back.sv
rtl/char_lcd_nibble_sequencer.sv
dv/tb_char_lcd_nibble_sequencer.sv
